### src/brl_pkg.sv
// Shared constants, types and helper functions for the blocked run-length tracker.
// No dependencies; compile first.
package brl_pkg;

	localparam int MAX_POSITIONS = 1024;
	localparam int HISTORY_DEPTH = 1024;

	localparam int POS_W = 11;
	localparam int OP_W  = 2;

	// bitmap organization: one memory row holds WORD_W consecutive positions
	localparam int WORD_W    = 64;
	localparam int MAP_WORDS = MAX_POSITIONS / WORD_W;
	localparam int MAP_AW    = $clog2(MAP_WORDS);
	localparam int BIT_AW    = $clog2(WORD_W);
	localparam int SH_W      = BIT_AW + 1;
	localparam int IDX_W     = MAP_AW + BIT_AW;

	// history entry: {new-mark flag, position}
	localparam int HIST_AW = $clog2(HISTORY_DEPTH);
	localparam int HIST_DW = POS_W + 1;
	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_BLOCK = OP_W'(0);
	localparam logic [OP_W-1:0] OP_QUERY = OP_W'(1);
	localparam logic [OP_W-1:0] OP_UNDO  = OP_W'(2);

	localparam logic [POS_W-1:0] LINE_LEN_RESET = POS_W'(1024);
	localparam logic [POS_W-1:0] MAX_POS_VAL    = POS_W'(MAX_POSITIONS);

	typedef logic [WORD_W-1:0] map_word_t;

	typedef struct packed {
		logic              en;
		logic [MAP_AW-1:0] addr;
		map_word_t         data;
	} map_wr_t;

	// index of highest set bit (0 if none)
	function automatic logic [BIT_AW-1:0] find_hi(input map_word_t w);
		logic [BIT_AW-1:0] r;
		r = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) r = BIT_AW'(i);
		end
		return r;
	endfunction

	// index of lowest set bit (0 if none)
	function automatic logic [BIT_AW-1:0] find_lo(input map_word_t w);
		logic [BIT_AW-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) r = BIT_AW'(i);
		end
		return r;
	endfunction

endpackage

### src/brl_if.sv
// Handshake channel interfaces: command in, result out, configuration write.
// Depends on brl_pkg.
interface brl_op_if import brl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [POS_W-1:0]  position;

	modport source (output valid, output operation, output position, input ready);
	modport sink   (input valid, input operation, input position, output ready);
endinterface

interface brl_res_if import brl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  run_length;

	modport source (output valid, output run_length, input ready);
	modport sink   (input valid, input run_length, output ready);
endinterface

interface brl_cfg_if import brl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  line_length;

	modport source (output valid, output line_length, input ready);
	modport sink   (input valid, input line_length, output ready);
endinterface

### src/brl_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module brl_ram #(
	parameter int DW = 8,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### src/brl_map_mem.sv
// Blocked-position bitmap: word-wide synchronous RAM with per-row valid bits.
// Depends on brl_pkg. A row never written reads as all zero.
module brl_map_mem import brl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MAP_AW-1:0] rd_addr,
	input  map_wr_t           wr,
	output map_word_t         rd_data
);

	map_word_t              mem [MAP_WORDS];
	map_word_t              rd_word_s1;
	logic                   rd_vld_s1;
	logic [MAP_WORDS-1:0]   row_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr.en) row_vld_q[wr.addr] <= 1'b1;
			rd_vld_s1 <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		rd_word_s1 <= mem[rd_addr];
	end

	assign rd_data = rd_vld_s1 ? rd_word_s1 : '0;

endmodule

### src/brl_seq.sv
// Operation sequencer: block/undo read-modify-write, query word scan, result register.
// Depends on brl_pkg and brl_if.
module brl_seq import brl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	brl_op_if.sink            cmd,
	brl_res_if.source         res,
	input  logic [POS_W-1:0]  n,
	output logic [MAP_AW-1:0] map_rd_addr,
	output map_wr_t           map_wr,
	input  map_word_t         map_rd_data,
	output logic [HIST_AW-1:0] hist_rd_addr,
	output logic              hist_wr_en,
	output logic [HIST_AW-1:0] hist_wr_addr,
	output logic [HIST_DW-1:0] hist_wr_data,
	input  logic [HIST_DW-1:0] hist_rd_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_BLK   = 3'd1;
	localparam logic [2:0] S_UHIST = 3'd2;
	localparam logic [2:0] S_UCLR  = 3'd3;
	localparam logic [2:0] S_QCHK  = 3'd4;
	localparam logic [2:0] S_LSCAN = 3'd5;
	localparam logic [2:0] S_RSCAN = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	localparam map_word_t ONES = '1;

	logic [2:0]        state_q, state_d;
	logic [IDX_W-1:0]  pidx_q, pidx_d;
	logic [MAP_AW-1:0] scan_w_q, scan_w_d;
	logic [POS_W-1:0]  left_q, left_d, right_q, right_d;
	logic              rdone_q, rdone_d;
	logic [CNT_W-1:0]  hist_cnt_q, hist_cnt_d;
	logic              res_valid_q, res_valid_d;
	logic [POS_W-1:0]  run_len_q, run_len_d;

	logic              accept, in_range, left_done, fresh;
	logic [IDX_W-1:0]  cmd_idx, n_idx, undo_idx;
	logic [MAP_AW-1:0] pos_w, wn;
	logic [BIT_AW-1:0] pos_b, lb;
	map_word_t         bit_oh, lo_mask, hi_mask, lim_cur, lim_scan;
	map_word_t         cur_left, cur_right, scan_r;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign in_range  = (cmd.position != '0) && (cmd.position <= n);
	assign cmd_idx   = IDX_W'(cmd.position - 1'b1);
	assign n_idx     = IDX_W'(n - 1'b1);
	assign undo_idx  = IDX_W'(hist_rd_data[POS_W-1:0] - 1'b1);
	assign fresh     = hist_rd_data[POS_W];

	assign pos_w = pidx_q[IDX_W-1:BIT_AW];
	assign pos_b = pidx_q[BIT_AW-1:0];
	assign wn    = n_idx[IDX_W-1:BIT_AW];
	assign lb    = n_idx[BIT_AW-1:0];

	assign bit_oh   = map_word_t'(1) << pos_b;
	assign lo_mask  = ONES >> (SH_W'(WORD_W) - {1'b0, pos_b});
	assign hi_mask  = ONES << ({1'b0, pos_b} + SH_W'(1));
	// clip scan to positions <= n
	assign lim_cur  = (pos_w == wn) ? (ONES >> (~lb)) : ONES;
	assign lim_scan = (scan_w_q == wn) ? (ONES >> (~lb)) : ONES;

	assign cur_left  = map_rd_data & lo_mask;
	assign cur_right = map_rd_data & hi_mask & lim_cur;
	assign scan_r    = map_rd_data & lim_scan;

	assign hist_rd_addr = HIST_AW'(hist_cnt_q - 1'b1);

	always_comb begin
		state_d      = state_q;
		pidx_d       = pidx_q;
		scan_w_d     = scan_w_q;
		left_d       = left_q;
		right_d      = right_q;
		rdone_d      = rdone_q;
		hist_cnt_d   = hist_cnt_q;
		res_valid_d  = res_valid_q;
		run_len_d    = run_len_q;
		left_done    = 1'b0;
		map_rd_addr  = pos_w;
		map_wr       = '0;
		hist_wr_en   = 1'b0;
		hist_wr_addr = HIST_AW'(hist_cnt_q);
		hist_wr_data = {~map_rd_data[pos_b], POS_W'(pidx_q) + POS_W'(1)};

		if (res_valid_q && res.ready) res_valid_d = 1'b0;

		case (state_q)
			S_IDLE: begin
				map_rd_addr = cmd_idx[IDX_W-1:BIT_AW];
				if (accept) begin
					pidx_d = cmd_idx;
					case (cmd.operation)
						OP_BLOCK: if (in_range) state_d = S_BLK;
						OP_QUERY: begin
							if (in_range) begin
								state_d = S_QCHK;
							end else begin
								left_d  = '0;
								right_d = POS_W'(1);
								state_d = S_EMIT;
							end
						end
						OP_UNDO: if (hist_cnt_q != '0) state_d = S_UHIST;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_BLK: begin
				map_wr.en   = 1'b1;
				map_wr.addr = pos_w;
				map_wr.data = map_rd_data | bit_oh;
				if (hist_cnt_q < CNT_W'(HISTORY_DEPTH)) begin
					hist_wr_en = 1'b1;
					hist_cnt_d = hist_cnt_q + 1'b1;
				end
				state_d = S_IDLE;
			end
			S_UHIST: begin
				hist_cnt_d = hist_cnt_q - 1'b1;
				if (fresh) begin
					pidx_d      = undo_idx;
					map_rd_addr = undo_idx[IDX_W-1:BIT_AW];
					state_d     = S_UCLR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_UCLR: begin
				map_wr.en   = 1'b1;
				map_wr.addr = pos_w;
				map_wr.data = map_rd_data & ~bit_oh;
				state_d     = S_IDLE;
			end
			S_QCHK: begin
				if (map_rd_data[pos_b]) begin
					left_d  = '0;
					right_d = POS_W'(1);
					state_d = S_EMIT;
				end else begin
					// right side within this word
					if (cur_right != '0) begin
						right_d = POS_W'({pos_w, find_lo(cur_right)}) + POS_W'(1);
						rdone_d = 1'b1;
					end else begin
						right_d = n + POS_W'(1);
						rdone_d = (pos_w == wn);
					end
					// left side within this word
					if (cur_left != '0) begin
						left_d    = POS_W'({pos_w, find_hi(cur_left)}) + POS_W'(1);
						left_done = 1'b1;
					end else if (pos_w == '0) begin
						left_d    = '0;
						left_done = 1'b1;
					end else begin
						scan_w_d    = pos_w - 1'b1;
						map_rd_addr = pos_w - 1'b1;
						state_d     = S_LSCAN;
					end
				end
			end
			S_LSCAN: begin
				if (map_rd_data != '0) begin
					left_d    = POS_W'({scan_w_q, find_hi(map_rd_data)}) + POS_W'(1);
					left_done = 1'b1;
				end else if (scan_w_q == '0) begin
					left_d    = '0;
					left_done = 1'b1;
				end else begin
					scan_w_d    = scan_w_q - 1'b1;
					map_rd_addr = scan_w_q - 1'b1;
				end
			end
			S_RSCAN: begin
				if (scan_r != '0) begin
					right_d = POS_W'({scan_w_q, find_lo(scan_r)}) + POS_W'(1);
					state_d = S_EMIT;
				end else if (scan_w_q == wn) begin
					right_d = n + POS_W'(1);
					state_d = S_EMIT;
				end else begin
					scan_w_d    = scan_w_q + 1'b1;
					map_rd_addr = scan_w_q + 1'b1;
				end
			end
			S_EMIT: begin
				if (!res_valid_q || res.ready) begin
					res_valid_d = 1'b1;
					run_len_d   = right_q - left_q - POS_W'(1);
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// left bound settled: go scan right unless already resolved
		if (left_done) begin
			if (rdone_d) begin
				state_d = S_EMIT;
			end else begin
				scan_w_d    = pos_w + 1'b1;
				map_rd_addr = pos_w + 1'b1;
				state_d     = S_RSCAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hist_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			hist_cnt_q  <= hist_cnt_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pidx_q    <= pidx_d;
		scan_w_q  <= scan_w_d;
		left_q    <= left_d;
		right_q   <= right_d;
		rdone_q   <= rdone_d;
		run_len_q <= run_len_d;
	end

	assign res.valid      = res_valid_q;
	assign res.run_length = run_len_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hist_cnt_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history count beyond depth");

	a_map_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		map_wr.en |-> (state_q == S_BLK || state_q == S_UCLR))
		else $error("bitmap write outside block/undo");

	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("result raised outside emit");

	a_undo_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UHIST |-> hist_cnt_q != '0)
		else $error("undo pop on empty history");

	a_emit_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && res_valid_q && !res.ready) |=> state_q == S_EMIT)
		else $error("query result lost while output stalled");

endmodule

### src/blocked_run_length_tracker_top.sv
// Top level of the blocked run-length tracker: config register, sequencer, memories.
// Depends on brl_pkg, brl_if, brl_ram, brl_map_mem, brl_seq.
// A query outside the line goes straight to the result register; any query result waits
// while the previous result is held. A new command is taken only once the last one is done.
// Query rate is set by the bitmap RAM read port: one 64-bit word scanned per cycle.
// Reset (arst_n low): bitmap rows read as clear, history empty, line_length = 1024.
module blocked_run_length_tracker_top import brl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	brl_op_if.sink    cmd,
	brl_res_if.source res,
	brl_cfg_if.sink   cfg
);

	logic [POS_W-1:0]   line_length_q;
	logic [POS_W-1:0]   n_eff;

	logic [MAP_AW-1:0]  map_rd_addr;
	map_wr_t            map_wr;
	map_word_t          map_rd_data;

	logic [HIST_AW-1:0] hist_rd_addr;
	logic               hist_wr_en;
	logic [HIST_AW-1:0] hist_wr_addr;
	logic [HIST_DW-1:0] hist_wr_data;
	logic [HIST_DW-1:0] hist_rd_data;

	// config transfer always taken; the user must write it only while the block is idle (not enforced here)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LEN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			line_length_q <= cfg.line_length;
		end
	end

	// lengths above the bitmap size clamp to it; zero leaves every position out of range
	assign n_eff = (line_length_q > MAX_POS_VAL) ? MAX_POS_VAL : line_length_q;

	// bitmap: one row per 64 positions, rows clear at reset via valid bits
	brl_map_mem u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (map_rd_addr),
		.wr      (map_wr),
		.rd_data (map_rd_data)
	);

	// undo history: {new-mark flag, position}, stack indexed by the history count
	brl_ram #(
		.DW (HIST_DW),
		.AW (HIST_AW)
	) u_hist (
		.clk     (clk),
		.wr_en   (hist_wr_en),
		.wr_addr (hist_wr_addr),
		.wr_data (hist_wr_data),
		.rd_addr (hist_rd_addr),
		.rd_data (hist_rd_data)
	);

	// sequencer owns the command/result transfers and all read-modify-write traffic
	brl_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.res          (res),
		.n            (n_eff),
		.map_rd_addr  (map_rd_addr),
		.map_wr       (map_wr),
		.map_rd_data  (map_rd_data),
		.hist_rd_addr (hist_rd_addr),
		.hist_wr_en   (hist_wr_en),
		.hist_wr_addr (hist_wr_addr),
		.hist_wr_data (hist_wr_data),
		.hist_rd_data (hist_rd_data)
	);

endmodule

### sim/tb_blocked_run_length_tracker_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for blocked_run_length_tracker_top: block, query and undo traffic
// against a behavioral copy of the blocked map and undo history. Uses brl_pkg and brl_if.
module tb_blocked_run_length_tracker_top;
	import brl_pkg::*;

	// op code 3 has no meaning in the block; it must be swallowed without a result
	localparam logic [OP_W-1:0] OP_UNUSED = OP_W'(3);
	localparam int CLK_HALF      = 4;
	// longest item is a query that scans every bitmap word; settle well past that
	localparam int SETTLE_CYCLES = 2 * MAP_WORDS + 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 700;
	localparam int SEGMENT_ITEMS = 50;

	logic clk;
	logic arst_n;

	brl_op_if  cmd_ch ();
	brl_res_if res_ch ();
	brl_cfg_if cfg_ch ();

	blocked_run_length_tracker_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// ---- behavioral copy of the block ----
	bit               blocked_q [0:MAX_POSITIONS];  // index 0 never used
	logic [POS_W-1:0] undo_pos  [HISTORY_DEPTH];
	bit               undo_new  [HISTORY_DEPTH];    // mark was fresh when recorded
	int               undo_depth;
	logic [POS_W-1:0] line_len_q;                   // raw register value, not clamped

	// run lengths still owed by the block, oldest first
	logic [POS_W-1:0] run_length_q [$];

	int snd_idle_pct;
	int rcv_idle_pct;
	int error_count;

	always begin
		clk = 1'b0;
		#(CLK_HALF);
		clk = 1'b1;
		#(CLK_HALF);
	end

	// register values above the map size act as the full map
	function automatic int active_length();
		return (int'(line_len_q) > MAX_POSITIONS) ? MAX_POSITIONS : int'(line_len_q);
	endfunction

	// free run around pos: nearest mark on each side, bounds 0 and n+1
	function automatic logic [POS_W-1:0] run_span(int pos, int n);
		int lo;
		int hi;
		lo = 0;
		hi = n + 1;
		for (int i = pos - 1; i >= 1; i--) begin
			if (blocked_q[i]) begin
				lo = i;
				break;
			end
		end
		for (int i = pos + 1; i <= n; i++) begin
			if (blocked_q[i]) begin
				hi = i;
				break;
			end
		end
		return POS_W'(hi - lo - 1);
	endfunction

	// update the copy for one accepted command; queries owe one run length
	function automatic void track_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos);
		int n;
		bit in_line;
		n = active_length();
		in_line = (pos >= 1) && (int'(pos) <= n);
		case (op)
			OP_BLOCK: begin
				if (in_line) begin
					// full history: mark still applied, just not recorded
					if (undo_depth < HISTORY_DEPTH) begin
						undo_pos[undo_depth] = pos;
						undo_new[undo_depth] = !blocked_q[pos];
						undo_depth++;
					end
					blocked_q[pos] = 1'b1;
				end
			end
			OP_QUERY: begin
				if (in_line && !blocked_q[pos])
					run_length_q = {run_length_q, run_span(int'(pos), n)};
				else
					run_length_q = {run_length_q, POS_W'(0)};
			end
			OP_UNDO: begin
				// marks above a lowered line length are still cleared here
				if (undo_depth > 0) begin
					undo_depth--;
					if (undo_new[undo_depth])
						blocked_q[undo_pos[undo_depth]] = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	// ---- drivers: change on falling edge, sample on rising edge ----

	// valid is left high after the transfer; the next call or drain() decides its fate
	task automatic send_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.position  <= pos;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		track_command(op, pos);
	endtask

	// hold off the sender until every owed run length is back, then let a
	// trailing block/undo finish (those never report completion)
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (run_length_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes only with the block idle
	task automatic set_line_length(logic [POS_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.line_length <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		line_len_q = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// receiver backpressure
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

	// ---- result checker ----
	always @(posedge clk) begin : run_length_check
		logic [POS_W-1:0] want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (run_length_q.size() == 0) begin
				$error("run_length: unexpected result, actual %0d", res_ch.run_length);
				error_count++;
			end else begin
				want = run_length_q.pop_front();
				if (res_ch.run_length !== want) begin
					$error("run_length mismatch: expected %0d, actual %0d",
						want, res_ch.run_length);
					error_count++;
				end
			end
		end
	end

	// ---- watchdog: cycles with no transfer on any channel ----
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("blocked_run_length_tracker_top regression: fail");
		$finish;
	end

	// ---- tests ----

	// field extremes, every op, repeat marks, empty history, out-of-line positions
	task automatic test_directed();
		send_command(OP_QUERY, 11'd1);              // empty line: whole length
		send_command(OP_QUERY, MAX_POS_VAL);
		send_command(OP_QUERY, '0);                 // position 0 answers 0
		send_command(OP_QUERY, MAX_POS_VAL + 11'd1); // past the line answers 0
		send_command(OP_QUERY, '1);
		send_command(OP_BLOCK, 11'd1);
		send_command(OP_BLOCK, MAX_POS_VAL);
		send_command(OP_QUERY, 11'd512);
		send_command(OP_QUERY, 11'd1);              // blocked answers 0
		send_command(OP_BLOCK, 11'd1);              // repeat mark, recorded as not fresh
		send_command(OP_UNDO, '1);                  // pops the repeat: 1 stays blocked
		send_command(OP_QUERY, 11'd2);
		send_command(OP_UNDO, '0);                  // clears the last position
		send_command(OP_QUERY, MAX_POS_VAL);
		send_command(OP_UNUSED, '1);                // no effect, no transfer out
		send_command(OP_BLOCK, '0);                 // ignored
		send_command(OP_BLOCK, MAX_POS_VAL + 11'd1); // ignored
		send_command(OP_BLOCK, '1);                 // ignored
		send_command(OP_UNDO, 11'd5);               // clears position 1
		send_command(OP_UNDO, 11'd5);               // history empty: nothing
		send_command(OP_QUERY, 11'd700);
		send_command(OP_UNUSED, '0);
		send_command(OP_QUERY, 11'd1);
	endtask

	// line length: lowered over existing marks, zero, above the map, tiny
	task automatic test_line_length_edges();
		send_command(OP_BLOCK, 11'd900);
		send_command(OP_BLOCK, 11'd10);
		set_line_length(11'd100);
		send_command(OP_QUERY, 11'd50);             // right bound is 101, mark at 900 hidden
		send_command(OP_QUERY, 11'd100);
		send_command(OP_QUERY, 11'd101);
		send_command(OP_BLOCK, 11'd101);            // outside the line: ignored
		send_command(OP_UNDO, '0);                  // pops 10
		send_command(OP_UNDO, '0);                  // pops 900, above the line, still cleared
		set_line_length(MAX_POS_VAL);
		send_command(OP_QUERY, 11'd900);
		set_line_length('0);                        // no position in use
		send_command(OP_BLOCK, 11'd1);
		send_command(OP_QUERY, 11'd1);
		set_line_length('1);                        // clamps to the map size
		send_command(OP_BLOCK, MAX_POS_VAL);
		send_command(OP_QUERY, 11'd1);
		send_command(OP_QUERY, MAX_POS_VAL + 11'd1);
		send_command(OP_UNDO, '0);
		set_line_length(MAX_POS_VAL + 11'd1);
		send_command(OP_QUERY, MAX_POS_VAL);
		set_line_length(11'd1);
		send_command(OP_QUERY, 11'd1);
		send_command(OP_BLOCK, 11'd1);
		send_command(OP_QUERY, 11'd1);
		send_command(OP_UNDO, '0);
		set_line_length(11'd2);
		send_command(OP_QUERY, 11'd2);
	endtask

	// short lines often; word boundaries, the full map and the clamp show up now and then
	function automatic logic [POS_W-1:0] pick_line_length();
		case ($urandom_range(9))
			0: return 11'd1;
			1: return 11'd2;
			2: return POS_W'(WORD_W - 1);
			3: return POS_W'(WORD_W);
			4: return POS_W'(WORD_W + 1);
			5: return MAX_POS_VAL;
			6: return POS_W'($urandom_range(2047, MAX_POSITIONS + 1));
			7: return POS_W'($urandom_range(MAX_POSITIONS, 1));
			default: return POS_W'($urandom_range(200, 3));
		endcase
	endfunction

	// in-line commands with random content, a few out-of-line and unused-op ones
	task automatic test_random_traffic(int count);
		int n;
		int pick;
		for (int k = 0; k < count; k++) begin
			if (k % SEGMENT_ITEMS == 0)
				set_line_length(pick_line_length());
			n = active_length();
			pick = $urandom_range(99);
			if (pick < 38)
				send_command(OP_BLOCK, POS_W'($urandom_range(n, 1)));
			else if (pick < 73)
				send_command(OP_QUERY, POS_W'($urandom_range(n, 1)));
			else if (pick < 93)
				send_command(OP_UNDO, POS_W'($urandom_range(2047, 0)));
			else
				send_command(OP_W'($urandom_range(3, 0)), POS_W'($urandom_range(2047, 0)));
		end
	endtask

	// ---- sequence ----
	initial begin
		arst_n               = 1'b0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.operation     = OP_BLOCK;
		cmd_ch.position      = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.line_length   = LINE_LEN_RESET;
		snd_idle_pct         = 29;
		rcv_idle_pct         = 58;
		error_count          = 0;
		undo_depth           = 0;
		line_len_q           = LINE_LEN_RESET;
		foreach (blocked_q[i])
			blocked_q[i] = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender lightly idle, receiver heavily stalled
		test_directed();
		test_line_length_edges();
		test_random_traffic(RANDOM_ITEMS / 3);

		// roles swapped
		drain();
		snd_idle_pct = 58;
		rcv_idle_pct = 29;
		test_random_traffic(RANDOM_ITEMS / 3);

		// full rate both sides
		drain();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		drain();
		if (error_count == 0)
			$display("blocked_run_length_tracker_top regression: pass");
		else
			$display("blocked_run_length_tracker_top regression: fail");
		$finish;
	end

endmodule

### files.f
src/brl_pkg.sv
src/brl_if.sv
src/brl_ram.sv
src/brl_map_mem.sv
src/brl_seq.sv
src/blocked_run_length_tracker_top.sv
sim/tb_blocked_run_length_tracker_top.sv
